/* src/rotating_window_rate_blocker_unit_assert.svh */
// Assertion macros shared by the rate blocker.
`ifndef ROTATING_WINDOW_RATE_BLOCKER_UNIT_ASSERT_SVH
`define ROTATING_WINDOW_RATE_BLOCKER_UNIT_ASSERT_SVH

// A condition implies another at the same edge.
`define RWRB_ASSERT_IMP(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

// A condition implies another at the next edge.
`define RWRB_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

`endif

/* src/rwrb_pkg.sv */
package rwrb_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned TMO_W = 20;
  localparam int unsigned REQ_W = 3;
  localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK   = 3'd0,
    REQ_QUERY  = 3'd1,
    REQ_LIGHT  = 3'd2,
    REQ_HEAVY  = 3'd3,
    REQ_PERM   = 3'd4,
    REQ_COUNT  = 3'd5,
    REQ_RSVD6  = 3'd6,
    REQ_RSVD7  = 3'd7
  } req_t;

  typedef enum logic [2:0] {
    CFG_LIGHT_TMO = 3'd0,
    CFG_HEAVY_TMO = 3'd1,
    CFG_LIGHT_THR = 3'd2,
    CFG_HEAVY_THR = 3'd3,
    CFG_MIN_THR   = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROBE_RD,
    ST_PROBE_CHK,
    ST_DATA_RD,
    ST_DATA_USE,
    ST_SWEEP_RD,
    ST_SWEEP_WR,
    ST_INIT
  } state_t;

  // Per-slot record: key, valid, four strike counts, minute count, mark.
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } key_rec_t;

  typedef struct packed {
    logic [CNT_W-1:0] l0;
    logic [CNT_W-1:0] l1;
    logic [CNT_W-1:0] h0;
    logic [CNT_W-1:0] h1;
    logic [CNT_W-1:0] m;
    logic             p;
  } cnt_rec_t;

  localparam int unsigned KEY_REC_W = $bits(key_rec_t);
  localparam int unsigned CNT_REC_W = $bits(cnt_rec_t);

  // Which of the two epoch tables a strike lands in.
  function automatic logic pick_table(input logic epoch, input logic [TMO_W-1:0] age,
                                      input logic [TMO_W-1:0] tmo);
    logic [TMO_W-1:0] half;
    half = tmo >> 1;
    if (half != '0 && age >= tmo - half) return ~epoch;
    return epoch;
  endfunction

endpackage

/* src/rotating_window_rate_blocker_unit.sv */
// Per-client rate blocker. start is taken when busy is low; each request gives
// exactly one result, shown for one cycle with out_valid, and the receiver
// cannot stall it. A keyed request probes up to PROBE_LIMIT slots, each read
// and then checked, through the slot memory's one read port, then reads the
// counts and writes them back as it registers its result.
// Tick and unknown requests give their result straight from idle, but a tick
// that ends a window walks the whole table, reading and then writing each slot.
// After reset a clearing pass over all ENTRIES slots runs before busy falls;
// configuration writes are taken at any time.
`include "rotating_window_rate_blocker_unit_assert.svh"

module rotating_window_rate_blocker_unit #(
  parameter int unsigned ENTRIES        = 1024,
  parameter int unsigned PROBE_LIMIT    = 8,
  parameter int unsigned MINUTE_SECONDS = 60
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_req_type,
  input  logic [63:0] in_client_key,
  output logic        out_valid,
  output logic [31:0] out_answer,
  output logic        out_table_full,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [rwrb_pkg::TMO_W-1:0] light_timeout_r, heavy_timeout_r;
  logic [rwrb_pkg::CNT_W-1:0] light_thr_r, heavy_thr_r, minute_thr_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_timeout_r <= 20'd60;
      heavy_timeout_r <= 20'd3600;
      light_thr_r     <= 32'd10;
      heavy_thr_r     <= 32'd3;
      minute_thr_r    <= 32'd600;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rwrb_pkg::CFG_LIGHT_TMO: light_timeout_r <= cfg_data[19:0];
        rwrb_pkg::CFG_HEAVY_TMO: heavy_timeout_r <= cfg_data[19:0];
        rwrb_pkg::CFG_LIGHT_THR: light_thr_r <= cfg_data;
        rwrb_pkg::CFG_HEAVY_THR: heavy_thr_r <= cfg_data;
        rwrb_pkg::CFG_MIN_THR:   minute_thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rwrb_ctrl #(
    .ENTRIES(ENTRIES), .PROBE_LIMIT(PROBE_LIMIT), .MINUTE_SECONDS(MINUTE_SECONDS)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start),
    .in_req_type(in_req_type), .in_client_key(in_client_key),
    .light_timeout(light_timeout_r), .heavy_timeout(heavy_timeout_r),
    .light_threshold(light_thr_r), .heavy_threshold(heavy_thr_r),
    .minute_threshold(minute_thr_r),
    .busy(busy), .out_valid(out_valid), .out_answer(out_answer),
    .out_table_full(out_table_full)
  );

  `RWRB_ASSERT_NEXT(a_one_result, clk, rst_n, out_valid, !out_valid)
  `RWRB_ASSERT_IMP(a_result_busy, clk, rst_n, out_valid, busy)
  `RWRB_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
  `RWRB_ASSERT_IMP(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

/* src/rwrb_ram.sv */
module rwrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

/* src/rwrb_ctrl.sv */
module rwrb_ctrl #(
  parameter int unsigned ENTRIES        = 1024,
  parameter int unsigned PROBE_LIMIT    = 8,
  parameter int unsigned MINUTE_SECONDS = 60
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rwrb_pkg::REQ_W-1:0] in_req_type,
  input  logic [rwrb_pkg::KEY_W-1:0] in_client_key,
  input  logic [rwrb_pkg::TMO_W-1:0] light_timeout,
  input  logic [rwrb_pkg::TMO_W-1:0] heavy_timeout,
  input  logic [rwrb_pkg::CNT_W-1:0] light_threshold,
  input  logic [rwrb_pkg::CNT_W-1:0] heavy_threshold,
  input  logic [rwrb_pkg::CNT_W-1:0] minute_threshold,
  output logic                      busy,
  output logic                      out_valid,
  output logic [rwrb_pkg::CNT_W-1:0] out_answer,
  output logic                      out_table_full
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned PW = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
  localparam int unsigned MW = $clog2(MINUTE_SECONDS + 1);

  rwrb_pkg::state_t state_r, state_nxt;
  logic [rwrb_pkg::REQ_W-1:0] req_r, req_nxt;
  logic [rwrb_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [PW-1:0] probe_r, probe_nxt;
  logic          probe_last_r, probe_last_nxt;
  logic          hit_r, hit_nxt, free_r, free_nxt;
  logic [AW-1:0] hit_slot_r, hit_slot_nxt, free_slot_r, free_slot_nxt;
  logic [rwrb_pkg::TMO_W-1:0] lage_r, lage_nxt, hage_r, hage_nxt;
  logic [MW-1:0] mage_r, mage_nxt;
  logic lep_r, lep_nxt, hep_r, hep_nxt;
  logic clr_l_r, clr_l_nxt, clr_h_r, clr_h_nxt, clr_m_r, clr_m_nxt;
  logic ov_r, ov_nxt, of_r, of_nxt;
  logic [rwrb_pkg::CNT_W-1:0] oa_r, oa_nxt;

  logic k_we, c_we;
  logic [AW-1:0] k_wa, c_wa, rd_a;
  rwrb_pkg::key_rec_t k_wd, k_rd;
  rwrb_pkg::cnt_rec_t c_wd, c_rd;

  rwrb_ram #(.WIDTH(rwrb_pkg::KEY_REC_W), .DEPTH(ENTRIES)) u_key_ram (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(rd_a), .rdata(k_rd)
  );
  rwrb_ram #(.WIDTH(rwrb_pkg::CNT_REC_W), .DEPTH(ENTRIES)) u_cnt_ram (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(rd_a), .rdata(c_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rwrb_pkg::ST_INIT;
      addr_r  <= '0;
      lage_r  <= '0;
      hage_r  <= '0;
      mage_r  <= '0;
      lep_r   <= 1'b0;
      hep_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      lage_r  <= lage_nxt;
      hage_r  <= hage_nxt;
      mage_r  <= mage_nxt;
      lep_r   <= lep_nxt;
      hep_r   <= hep_nxt;
      ov_r    <= ov_nxt;
    end
    req_r <= req_nxt;
    key_r <= key_nxt;
    probe_r <= probe_nxt;
    probe_last_r <= probe_last_nxt;
    hit_r <= hit_nxt;
    free_r <= free_nxt;
    hit_slot_r <= hit_slot_nxt;
    free_slot_r <= free_slot_nxt;
    clr_l_r <= clr_l_nxt;
    clr_h_r <= clr_h_nxt;
    clr_m_r <= clr_m_nxt;
    of_r <= of_nxt;
    oa_r <= oa_nxt;
  end

  logic [rwrb_pkg::TMO_W-1:0] lage_inc, hage_inc;
  logic [MW-1:0] mage_inc;
  logic tl, th;
  logic [rwrb_pkg::CNT_W-1:0] cur, thr;
  logic [rwrb_pkg::CNT_W:0] lsum, hsum;
  logic [AW-1:0] slot;
  logic have;
  rwrb_pkg::cnt_rec_t rec, nrec;
  logic empty;

  always_comb begin
    state_nxt = state_r;
    req_nxt = req_r;
    key_nxt = key_r;
    addr_nxt = addr_r;
    probe_nxt = probe_r;
    probe_last_nxt = probe_last_r;
    hit_nxt = hit_r;
    free_nxt = free_r;
    hit_slot_nxt = hit_slot_r;
    free_slot_nxt = free_slot_r;
    lage_nxt = lage_r;
    hage_nxt = hage_r;
    mage_nxt = mage_r;
    lep_nxt = lep_r;
    hep_nxt = hep_r;
    clr_l_nxt = clr_l_r;
    clr_h_nxt = clr_h_r;
    clr_m_nxt = clr_m_r;
    ov_nxt = 1'b0;
    of_nxt = of_r;
    oa_nxt = oa_r;
    k_we = 1'b0;
    c_we = 1'b0;
    k_wa = addr_r;
    c_wa = addr_r;
    k_wd = '0;
    c_wd = '0;
    rd_a = addr_r;
    lage_inc = lage_r + 1'b1;
    hage_inc = hage_r + 1'b1;
    mage_inc = mage_r + 1'b1;
    tl = rwrb_pkg::pick_table(lep_r, lage_r, light_timeout);
    th = rwrb_pkg::pick_table(hep_r, hage_r, heavy_timeout);
    slot = hit_r ? hit_slot_r : free_slot_r;
    have = hit_r | free_r;
    rec = hit_r ? c_rd : '0;
    nrec = rec;
    cur = '0;
    thr = '0;
    lsum = '0;
    hsum = '0;
    empty = 1'b0;

    unique case (state_r)
      // After reset every slot is cleared, one per cycle.
      rwrb_pkg::ST_INIT: begin
        k_we = 1'b1;
        c_we = 1'b1;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(ENTRIES - 1)) state_nxt = rwrb_pkg::ST_IDLE;
      end
      rwrb_pkg::ST_IDLE: begin
        // While the result is shown the block is busy and takes nothing.
        if (start && !ov_r) begin
          req_nxt = in_req_type;
          key_nxt = in_client_key;
          if (in_req_type == rwrb_pkg::REQ_TICK) begin
            clr_l_nxt = (lage_inc >= light_timeout);
            clr_h_nxt = (hage_inc >= heavy_timeout);
            clr_m_nxt = (32'(mage_inc) >= 32'(MINUTE_SECONDS));
            lage_nxt = clr_l_nxt ? '0 : lage_inc;
            hage_nxt = clr_h_nxt ? '0 : hage_inc;
            mage_nxt = clr_m_nxt ? '0 : mage_inc;
            of_nxt = 1'b0;
            oa_nxt = '0;
            addr_nxt = '0;
            if (clr_l_nxt | clr_h_nxt | clr_m_nxt) begin
              state_nxt = rwrb_pkg::ST_SWEEP_RD;
            end else begin
              ov_nxt = 1'b1;
            end
          end else if (in_req_type == rwrb_pkg::REQ_RSVD6 ||
                       in_req_type == rwrb_pkg::REQ_RSVD7) begin
            of_nxt = 1'b0;
            oa_nxt = '0;
            ov_nxt = 1'b1;
          end else begin
            addr_nxt = in_client_key[AW-1:0];
            probe_nxt = '0;
            probe_last_nxt = (PROBE_LIMIT == 1);
            hit_nxt = 1'b0;
            free_nxt = 1'b0;
            state_nxt = rwrb_pkg::ST_PROBE_RD;
          end
        end
      end
      rwrb_pkg::ST_PROBE_RD: begin
        state_nxt = rwrb_pkg::ST_PROBE_CHK;
      end
      rwrb_pkg::ST_PROBE_CHK: begin
        if (k_rd.valid && k_rd.key == key_r) begin
          hit_nxt = 1'b1;
          hit_slot_nxt = addr_r;
        end else if (!k_rd.valid && !free_r) begin
          free_nxt = 1'b1;
          free_slot_nxt = addr_r;
        end
        if (hit_nxt || probe_last_r) begin
          addr_nxt = hit_nxt ? addr_r : free_slot_nxt;
          state_nxt = rwrb_pkg::ST_DATA_RD;
        end else begin
          addr_nxt = addr_r + 1'b1;
          probe_nxt = probe_r + 1'b1;
          probe_last_nxt = (32'(probe_r) + 32'd2 >= 32'(PROBE_LIMIT));
          state_nxt = rwrb_pkg::ST_PROBE_RD;
        end
      end
      rwrb_pkg::ST_DATA_RD: begin
        state_nxt = rwrb_pkg::ST_DATA_USE;
      end
      rwrb_pkg::ST_DATA_USE: begin
        ov_nxt = 1'b1;
        of_nxt = 1'b0;
        state_nxt = rwrb_pkg::ST_IDLE;
        k_wa = slot;
        c_wa = slot;
        k_wd.valid = 1'b1;
        k_wd.key = key_r;
        unique case (req_r)
          rwrb_pkg::REQ_QUERY: begin
            lsum = {1'b0, rec.l0} + {1'b0, rec.l1};
            hsum = {1'b0, rec.h0} + {1'b0, rec.h1};
            oa_nxt = {31'd0, (hsum >= {1'b0, heavy_threshold}) ||
                             (lsum >= {1'b0, light_threshold}) ||
                             (rec.m >= minute_threshold) || rec.p};
          end
          rwrb_pkg::REQ_LIGHT, rwrb_pkg::REQ_HEAVY: begin
            if (req_r == rwrb_pkg::REQ_LIGHT) begin
              cur = tl ? rec.l1 : rec.l0;
              thr = light_threshold;
            end else begin
              cur = th ? rec.h1 : rec.h0;
              thr = heavy_threshold;
            end
            if (cur >= thr) begin
              oa_nxt = cur;
            end else begin
              oa_nxt = cur + 1'b1;
              if (req_r == rwrb_pkg::REQ_LIGHT) begin
                if (tl) nrec.l1 = oa_nxt; else nrec.l0 = oa_nxt;
              end else begin
                if (th) nrec.h1 = oa_nxt; else nrec.h0 = oa_nxt;
              end
              of_nxt = !have;
              k_we = have;
              c_we = have;
              c_wd = nrec;
            end
          end
          rwrb_pkg::REQ_PERM: begin
            nrec.p = 1'b1;
            oa_nxt = 32'd1;
            of_nxt = !have;
            k_we = have;
            c_we = have;
            c_wd = nrec;
          end
          rwrb_pkg::REQ_COUNT: begin
            cur = (rec.m != rwrb_pkg::CNT_MAX) ? rec.m + 1'b1 : rec.m;
            nrec.m = cur;
            oa_nxt = {31'd0, cur > minute_threshold};
            of_nxt = !have;
            k_we = have;
            c_we = have;
            c_wd = nrec;
          end
          default: oa_nxt = '0;
        endcase
      end
      rwrb_pkg::ST_SWEEP_RD: begin
        state_nxt = rwrb_pkg::ST_SWEEP_WR;
      end
      // Each slot is read, then written: clear the expiring tables and the minute count, drop empty slots.
      rwrb_pkg::ST_SWEEP_WR: begin
        nrec = c_rd;
        if (clr_l_r) begin
          if (lep_r) nrec.l1 = '0; else nrec.l0 = '0;
        end
        if (clr_h_r) begin
          if (hep_r) nrec.h1 = '0; else nrec.h0 = '0;
        end
        if (clr_m_r) nrec.m = '0;
        empty = (nrec == '0);
        c_we = 1'b1;
        c_wd = nrec;
        k_we = empty;
        k_wd = '0;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(ENTRIES - 1)) begin
          lep_nxt = lep_r ^ clr_l_r;
          hep_nxt = hep_r ^ clr_h_r;
          ov_nxt = 1'b1;
          state_nxt = rwrb_pkg::ST_IDLE;
        end else begin
          state_nxt = rwrb_pkg::ST_SWEEP_RD;
        end
      end
      default: state_nxt = rwrb_pkg::ST_IDLE;
    endcase
  end

  assign busy = (state_r != rwrb_pkg::ST_IDLE) || ov_r;
  assign out_valid = ov_r;
  assign out_answer = oa_r;
  assign out_table_full = of_r;

endmodule
